### design/flic_pkg.sv
`default_nettype none
package flic_pkg;
    localparam int unsigned LINE_PITCH  = 320;
    localparam int unsigned FRAME_BYTES = 64000;
    localparam logic [16:0] POS_MAX     = 17'h1ffff;

    localparam logic [15:0] CT_PAL6   = 16'h000b;
    localparam logic [15:0] CT_PAL8   = 16'h0004;
    localparam logic [15:0] CT_BDELTA = 16'h000c;
    localparam logic [15:0] CT_WDELTA = 16'h0007;
    localparam logic [15:0] CT_BRUN   = 16'h000f;

    localparam logic [1:0] KIND_RUN = 2'd0;
    localparam logic [1:0] KIND_PAL = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE, PH_PAL_C0, PH_PAL_C1, PH_PAL_F0, PH_PAL_F1, PH_PAL_DATA,
        PH_LD_B0, PH_LD_B1, PH_LD_N0, PH_LD_N1, PH_WD_N0, PH_WD_N1,
        PH_LINE_BYTE, PH_LINE_W0, PH_LINE_W1, PH_SKIP, PH_COUNT,
        PH_RUN_V0, PH_RUN_V1, PH_LIT_B, PH_LIT_W0, PH_LIT_W1
    } phase_t;

    typedef enum logic [2:0] {
        AK_NONE, AK_PAL6, AK_PAL8, AK_BDELTA, AK_WDELTA, AK_BRUN
    } akind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [8:0]  run_length;
        logic [7:0]  value_even;
        logic [7:0]  value_odd;
        logic [1:0]  component;
    } result_t;
endpackage
`default_nettype wire

### design/flic_core.sv
`default_nettype none
module flic_core
    import flic_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [9:0]  image_height,
    input  wire logic        step,
    input  wire logic        action,
    input  wire logic [15:0] chunk_type,
    input  wire logic [7:0]  data_byte,
    output logic             res_valid,
    output result_t          res
);
    phase_t      phase_reg, phase_next;
    akind_t      ak_reg, ak_next;
    logic [15:0] line_reg, line_next, limit_reg, limit_next;
    logic [15:0] pkts_reg, pkts_next, skip_reg, skip_next;
    logic [16:0] pos_reg, pos_next;
    logic [7:0]  runl_reg, runl_next, held_reg, held_next;
    logic [17:0] pall_reg, pall_next;
    logic [7:0]  pent_reg, pent_next;
    logic [1:0]  pcomp_reg, pcomp_next;

    logic [7:0]  b;
    logic [15:0] word;
    logic [16:0] sum17;
    logic [17:0] possum;
    logic [28:0] prod;
    logic [16:0] lineidx;
    logic [8:0]  runlen;
    logic        high;
    logic        rep;

    function automatic logic [16:0] sat17(input logic [17:0] v);
        return (v > {1'b0, POS_MAX}) ? POS_MAX : v[16:0];
    endfunction

    always_comb begin
        phase_next = phase_reg; ak_next = ak_reg; line_next = line_reg;
        limit_next = limit_reg; pkts_next = pkts_reg; skip_next = skip_reg;
        pos_next = pos_reg; runl_next = runl_reg; held_next = held_reg;
        pall_next = pall_reg; pent_next = pent_reg; pcomp_next = pcomp_reg;
        res_valid = 1'b0;
        res = '0;
        b = data_byte;
        word = {data_byte, held_reg};
        sum17 = '0;
        possum = '0;
        prod = '0;
        lineidx = '0;
        runlen = '0;
        high = data_byte[7];
        rep = 1'b0;
        if (step) begin
            if (action) begin
                line_next = '0; limit_next = '0; pkts_next = '0; pos_next = '0;
                skip_next = '0; runl_next = '0; held_next = '0; pall_next = '0;
                pent_next = '0; pcomp_next = '0;
                unique case (chunk_type)
                    CT_PAL6: begin ak_next = AK_PAL6; phase_next = PH_PAL_C0; end
                    CT_PAL8: begin ak_next = AK_PAL8; phase_next = PH_PAL_C0; end
                    CT_BDELTA: begin ak_next = AK_BDELTA; phase_next = PH_LD_B0; end
                    CT_WDELTA: begin ak_next = AK_WDELTA; phase_next = PH_WD_N0; end
                    CT_BRUN: begin
                        ak_next = AK_BRUN;
                        limit_next = {6'd0, image_height};
                        phase_next = (image_height == 10'd0) ? PH_IDLE : PH_LINE_BYTE;
                    end
                    default: begin
                        ak_next = AK_NONE;
                        phase_next = PH_IDLE;
                        res_valid = 1'b1;
                        res.kind = KIND_ERR;
                        res.address = chunk_type;
                    end
                endcase
            end else begin
                unique case (phase_reg)
                    PH_PAL_C0: begin held_next = b; phase_next = PH_PAL_C1; end
                    PH_PAL_C1: begin
                        pall_next = {2'b00, word[7:0], word[15:8]}
                                  + {1'b0, word[7:0], word[15:8], 1'b0};
                        phase_next = PH_PAL_F0;
                    end
                    PH_PAL_F0: phase_next = PH_PAL_F1;
                    PH_PAL_F1: begin
                        pent_next = b;
                        pcomp_next = '0;
                        phase_next = (pall_reg != '0) ? PH_PAL_DATA : PH_IDLE;
                    end
                    PH_PAL_DATA: begin
                        res_valid = 1'b1;
                        res.kind = KIND_PAL;
                        res.address = {8'd0, pent_reg};
                        res.value_even = (ak_reg == AK_PAL8) ? {2'b00, b[7:2]} : b;
                        res.value_odd = res.value_even;
                        res.component = pcomp_reg;
                        if (pcomp_reg == 2'd2) begin
                            pcomp_next = '0;
                            pent_next = pent_reg + 8'd1;
                        end else begin
                            pcomp_next = pcomp_reg + 2'd1;
                        end
                        pall_next = pall_reg - 18'd1;
                        if (pall_reg == 18'd1) phase_next = PH_IDLE;
                    end
                    PH_LD_B0, PH_LD_N0, PH_WD_N0, PH_LINE_W0, PH_LIT_W0: begin
                        held_next = b;
                        unique case (phase_reg)
                            PH_LD_B0: phase_next = PH_LD_B1;
                            PH_LD_N0: phase_next = PH_LD_N1;
                            PH_WD_N0: phase_next = PH_WD_N1;
                            PH_LINE_W0: phase_next = PH_LINE_W1;
                            default: phase_next = PH_LIT_W1;
                        endcase
                    end
                    PH_LD_B1: begin line_next = word; phase_next = PH_LD_N0; end
                    PH_LD_N1: begin
                        sum17 = {1'b0, line_reg} + {1'b0, word};
                        limit_next = sum17[16] ? 16'hffff : sum17[15:0];
                        phase_next = (line_reg >= limit_next) ? PH_IDLE
                                   : PH_LINE_BYTE;
                    end
                    PH_WD_N1: begin
                        line_next = '0;
                        limit_next = word[15] ? 16'd0 : word;
                        phase_next = (word[15] || word == '0) ? PH_IDLE : PH_LINE_W0;
                    end
                    PH_LINE_BYTE, PH_LINE_W1: begin
                        if (phase_reg == PH_LINE_W1 && word[15]) begin
                            sum17 = {1'b0, skip_reg} + (17'h10000 - {1'b0, word});
                            skip_next = sum17[16] ? 16'hffff : sum17[15:0];
                            phase_next = PH_LINE_W0;
                        end else begin
                            lineidx = (phase_reg == PH_LINE_W1)
                                    ? {1'b0, line_reg} + {1'b0, skip_reg}
                                    : {1'b0, line_reg};
                            prod = 29'(lineidx * 17'(LINE_PITCH));
                            pos_next = (prod > 29'(POS_MAX)) ? POS_MAX : prod[16:0];
                            pkts_next = (phase_reg == PH_LINE_W1) ? word : {8'd0, b};
                        end
                    end
                    PH_SKIP: begin
                        pos_next = sat17({1'b0, pos_reg} + 18'(b));
                        phase_next = PH_COUNT;
                    end
                    PH_COUNT: begin
                        rep = (ak_reg == AK_BRUN) ? !high : high;
                        runl_next = high ? 8'(9'd256 - 9'(b)) : b;
                        if (rep) phase_next = PH_RUN_V0;
                        else if (runl_next != '0)
                            phase_next = (ak_reg == AK_WDELTA) ? PH_LIT_W0 : PH_LIT_B;
                        else pkts_next = pkts_reg - 16'd1;
                    end
                    PH_RUN_V0: begin
                        if (ak_reg == AK_WDELTA) begin
                            held_next = b;
                            phase_next = PH_RUN_V1;
                        end else begin
                            if (runl_reg != '0) begin
                                res_valid = 1'b1;
                                res.address = pos_reg[15:0];
                                res.run_length = {1'b0, runl_reg};
                                res.value_even = b;
                                res.value_odd = b;
                                pos_next = sat17({1'b0, pos_reg} + 18'(runl_reg));
                            end
                            pkts_next = pkts_reg - 16'd1;
                        end
                    end
                    PH_RUN_V1, PH_LIT_B, PH_LIT_W1: begin
                        runlen = (phase_reg == PH_RUN_V1) ? {runl_reg, 1'b0}
                               : (phase_reg == PH_LIT_W1) ? 9'd2 : 9'd1;
                        res_valid = 1'b1;
                        res.address = pos_reg[15:0];
                        res.run_length = runlen;
                        res.value_even = (phase_reg == PH_LIT_B) ? b : held_reg;
                        res.value_odd = b;
                        pos_next = sat17({1'b0, pos_reg} + 18'(runlen));
                        if (phase_reg == PH_RUN_V1) begin
                            pkts_next = pkts_reg - 16'd1;
                        end else begin
                            runl_next = runl_reg - 8'd1;
                            if (runl_reg == 8'd1) pkts_next = pkts_reg - 16'd1;
                            else if (phase_reg == PH_LIT_W1) phase_next = PH_LIT_W0;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
                // packet sequencing after line start or packet completion
                if ((phase_reg == PH_LINE_BYTE)
                    || (phase_reg == PH_LINE_W1 && !word[15])
                    || (phase_reg == PH_COUNT && !rep && runl_next == '0)
                    || (phase_reg == PH_RUN_V0 && ak_reg != AK_WDELTA)
                    || (phase_reg == PH_RUN_V1)
                    || ((phase_reg == PH_LIT_B || phase_reg == PH_LIT_W1)
                        && runl_reg == 8'd1)) begin
                    if (pkts_next == '0) begin
                        if (pos_next > 17'(FRAME_BYTES)) phase_next = PH_IDLE;
                        else begin
                            line_next = line_reg + 16'd1;
                            if (line_next >= limit_reg) phase_next = PH_IDLE;
                            else phase_next = (ak_reg == AK_WDELTA) ? PH_LINE_W0
                                            : PH_LINE_BYTE;
                        end
                    end else if (pos_next >= 17'(FRAME_BYTES)) phase_next = PH_IDLE;
                    else phase_next = (ak_reg == AK_BRUN) ? PH_COUNT : PH_SKIP;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; ak_reg <= AK_NONE; line_reg <= '0;
            limit_reg <= '0; pkts_reg <= '0; skip_reg <= '0; pos_reg <= '0;
            runl_reg <= '0; held_reg <= '0; pall_reg <= '0; pent_reg <= '0;
            pcomp_reg <= '0;
        end else begin
            phase_reg <= phase_next; ak_reg <= ak_next; line_reg <= line_next;
            limit_reg <= limit_next; pkts_reg <= pkts_next; skip_reg <= skip_next;
            pos_reg <= pos_next; runl_reg <= runl_next; held_reg <= held_next;
            pall_reg <= pall_next; pent_reg <= pent_next; pcomp_reg <= pcomp_next;
        end
    end
endmodule
`default_nettype wire

### design/flic_chunk_decoder_top.sv
`default_nettype none
// channel   handshake          payload
// s_        s_valid/s_ready    s_action, s_chunk_type, s_data_byte
// m_        m_valid/m_ready    m_kind, m_address, m_run_length, m_value_even,
//                              m_value_odd, m_component
// cfg       cfg_we             cfg_data (image_height)
// One beat per cycle while s_ready is high; its result, if any, is registered.
// The input beat is taken whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous) idles the decoder and sets image_height to 200.
// A stalled result holds the input side only while it is not taken.
module flic_chunk_decoder_top
    import flic_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [15:0] s_chunk_type,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [15:0]      m_address,
    output logic [8:0]       m_run_length,
    output logic [7:0]       m_value_even,
    output logic [7:0]       m_value_odd,
    output logic [1:0]       m_component
);
    logic [9:0] height_reg;
    logic       valid_reg;
    result_t    out_reg;
    logic       res_valid;
    result_t    res;
    logic       step;

    assign s_ready = !valid_reg || m_ready;
    assign step = s_valid && s_ready;

    flic_core u_core (
        .aclk(aclk), .aresetn(aresetn), .image_height(height_reg), .step(step),
        .action(s_action), .chunk_type(s_chunk_type), .data_byte(s_data_byte),
        .res_valid(res_valid), .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= 10'd200;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_we) height_reg <= cfg_data;
            if (s_ready) valid_reg <= step && res_valid;
        end
        if (s_ready && step && res_valid) out_reg <= res;
    end

    assign m_valid = valid_reg;
    assign m_kind = out_reg.kind;
    assign m_address = out_reg.address;
    assign m_run_length = out_reg.run_length;
    assign m_value_even = out_reg.value_even;
    assign m_value_odd = out_reg.value_odd;
    assign m_component = out_reg.component;
endmodule
`default_nettype wire
